// ===== src/message_ring_log_unit_defines.svh =====
// assertion macros for the message ring log unit
`ifndef MESSAGE_RING_LOG_UNIT_DEFINES_SVH
`define MESSAGE_RING_LOG_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// condition that must hold at every clock edge out of reset
`define MRL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must hold in the cycle after a trigger
`define MRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MRL_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/mrl_pkg.sv =====
// shared types and constants of the message ring log unit
package mrl_pkg;

    localparam int OP_W    = 2;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 5;
    localparam int BYTES_W = 9;

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_REWIND = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic app_open;
        logic app_byte;
        logic rd_check;
        logic rd_addr;
        logic rd_finish;
        logic rewind;
        logic clear_all;
        logic fetch_oldest;
        logic out_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic past_end;
    } status_t;

endpackage

// ===== src/mrl_ram.sv =====
// generic single write port ram with registered read
module mrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mrl_ctrl.sv =====
// controller state machine of the message ring log unit
`include "message_ring_log_unit_defines.svh"

module mrl_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [mrl_pkg::OP_W-1:0]  op,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mrl_pkg::cmd_t             cmd,
    input  mrl_pkg::status_t          status
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_APP_OPEN  = 11'b000_0000_0010,
        S_APP_FETCH = 11'b000_0000_0100,
        S_APP_BYTE  = 11'b000_0000_1000,
        S_RD_CHECK  = 11'b000_0001_0000,
        S_RD_ADDR   = 11'b000_0010_0000,
        S_RD_DATA   = 11'b000_0100_0000,
        S_REWIND    = 11'b000_1000_0000,
        S_CLEAR     = 11'b001_0000_0000,
        S_FETCH     = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (mrl_pkg::op_t'(op))
                        mrl_pkg::OP_APPEND: state_next = S_APP_OPEN;
                        mrl_pkg::OP_READ:   state_next = S_RD_CHECK;
                        mrl_pkg::OP_REWIND: state_next = S_REWIND;
                        mrl_pkg::OP_CLEAR:  state_next = S_CLEAR;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_APP_OPEN:
            begin
                cmd.app_open = 1'b1;
                state_next   = S_APP_FETCH;
            end
            S_APP_FETCH:
            begin
                cmd.fetch_oldest = 1'b1;
                state_next       = S_APP_BYTE;
            end
            S_APP_BYTE:
            begin
                cmd.app_byte = 1'b1;
                state_next   = S_FETCH;
            end
            S_RD_CHECK:
            begin
                cmd.rd_check = 1'b1;
                state_next   = status.past_end ? S_FETCH : S_RD_ADDR;
            end
            S_RD_ADDR:
            begin
                cmd.rd_addr = 1'b1;
                state_next  = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                cmd.rd_finish = 1'b1;
                state_next    = S_FETCH;
            end
            S_REWIND:
            begin
                cmd.rewind = 1'b1;
                state_next = S_FETCH;
            end
            S_CLEAR:
            begin
                cmd.clear_all = 1'b1;
                state_next    = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch_oldest = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MRL_ASSERT_NEXT(a_item_busy, clk, rst_n, in_valid && in_ready, !in_ready, "item accepted back to back")

endmodule

// ===== src/mrl_dpath.sv =====
// datapath of the message ring log unit: pointers, counters, stores and result
`include "message_ring_log_unit_defines.svh"

module mrl_dpath #(
    parameter int STORE_BYTES = 256,
    parameter int MAX_MSGS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrl_pkg::cmd_t                 cmd,
    output mrl_pkg::status_t              status,
    input  logic [mrl_pkg::DATA_W-1:0]    data,
    input  logic                          last,
    output logic [mrl_pkg::DATA_W-1:0]    rd_byte,
    output logic                          msg_end,
    output logic                          log_end,
    output logic [mrl_pkg::COUNT_W-1:0]   msg_count,
    output logic [mrl_pkg::BYTES_W-1:0]   bytes_used,
    output logic                          truncated
);

    localparam int SLOTS = MAX_MSGS + 1;
    localparam int AW    = $clog2(STORE_BYTES);
    localparam int AW1   = AW + 1;
    localparam int LW    = $clog2(STORE_BYTES + 1);
    localparam int SW    = $clog2(SLOTS);
    localparam int SW1   = SW + 1;
    localparam int DW    = mrl_pkg::DATA_W;
    localparam int CNT_W = mrl_pkg::COUNT_W;
    localparam int BYT_W = mrl_pkg::BYTES_W;

    localparam logic [LW-1:0]  STORE_LEN = LW'(STORE_BYTES);
    localparam logic [AW:0]    STORE_X   = AW1'(STORE_BYTES);
    localparam logic [AW-1:0]  PTR_MAX   = AW'(STORE_BYTES - 1);
    localparam logic [SW-1:0]  MSG_MAX   = SW'(MAX_MSGS);
    localparam logic [SW:0]    SLOTS_X   = SW1'(SLOTS);

    // circular difference a - b of two store offsets
    function automatic logic [AW-1:0] ptr_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] t;
        if (a >= b)
        begin
            t = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            t = {1'b0, a} + STORE_X - {1'b0, b};
        end
        return t[AW-1:0];
    endfunction

    // circular sum of two store offsets
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= STORE_X)
        begin
            t = t - STORE_X;
        end
        return t[AW-1:0];
    endfunction

    // next store offset
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        return (a == PTR_MAX) ? '0 : a + AW'(1);
    endfunction

    // length reduced to a store offset
    function automatic logic [AW-1:0] len_mod(input logic [LW-1:0] l);
        return (l == STORE_LEN) ? '0 : l[AW-1:0];
    endfunction

    // distance as a byte count, a full store when the ends meet
    function automatic logic [LW-1:0] span(input logic [AW-1:0] d);
        return (d == '0) ? STORE_LEN : LW'(d);
    endfunction

    // slot index advanced by k places around the start queue
    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a, input logic [SW:0] k);
        logic [SW:0] t;
        t = {1'b0, a} + k;
        if (t >= SLOTS_X)
        begin
            t = t - SLOTS_X;
        end
        return t[SW-1:0];
    endfunction

    // control state
    logic [SW-1:0] oldest_slot_reg, oldest_slot_next;
    logic [SW-1:0] held_count_reg,  held_count_next;
    logic [AW-1:0] write_ptr_reg,   write_ptr_next;
    logic [LW-1:0] open_len_reg,    open_len_next;
    logic [SW-1:0] read_msg_reg,    read_msg_next;
    logic [AW-1:0] read_ptr_reg,    read_ptr_next;

    // item and result payload
    logic [DW-1:0]    item_data_reg;
    logic             item_last_reg;
    logic [AW-1:0]    start_reg;
    logic [DW-1:0]    res_byte_reg;
    logic             res_mend_reg;
    logic             res_lend_reg;
    logic             res_trunc_reg;
    logic [DW-1:0]    rd_byte_reg;
    logic             msg_end_reg;
    logic             log_end_reg;
    logic [CNT_W-1:0] msg_count_reg;
    logic [BYT_W-1:0] bytes_used_reg;
    logic             truncated_reg;

    // memory ports
    logic          st_we;
    logic [SW-1:0] st_waddr;
    logic          st_re;
    logic [SW-1:0] st_raddr;
    logic [AW-1:0] st_rdata;
    logic          bs_we;
    logic [AW-1:0] bs_raddr;
    logic [DW-1:0] bs_rdata;

    // derived values
    logic [AW-1:0] open_start;
    logic          past_end;
    logic          full_now;
    logic          trunc_now;
    logic          drop_open;
    logic          drop_byte;
    logic          drop;
    logic          more_after;
    logic [AW-1:0] msg_stop;
    logic [LW-1:0] msg_len;
    logic [LW-1:0] ptr_step;
    logic          at_end;
    logic [LW-1:0] bytes_now;

    assign open_start = ptr_sub(write_ptr_reg, len_mod(open_len_reg));
    assign past_end   = (read_msg_reg >= held_count_reg);
    assign full_now   = (held_count_reg >= MSG_MAX);
    assign trunc_now  = (open_len_reg == STORE_LEN);

    // oldest message goes when a new one starts at the limit or a byte lands on its start
    assign drop_open = cmd.app_open && (open_len_reg == '0) && full_now;
    assign drop_byte = cmd.app_byte && !trunc_now && (held_count_reg != '0)
                       && (st_rdata == write_ptr_reg);
    assign drop      = drop_open || drop_byte;

    // length of the message under the read cursor
    assign more_after = (({1'b0, read_msg_reg} + SW1'(1)) < {1'b0, held_count_reg});
    assign msg_stop   = more_after ? st_rdata : open_start;
    assign msg_len    = span(ptr_sub(msg_stop, start_reg));
    assign ptr_step   = LW'(read_ptr_reg) + LW'(1);
    assign at_end     = (ptr_step >= msg_len);

    // bytes from the oldest start to the open message
    assign bytes_now = (held_count_reg == '0) ? '0 : span(ptr_sub(open_start, st_rdata));

    assign status.past_end = past_end;

    // message start queue
    assign st_we    = cmd.app_open && (open_len_reg == '0);
    assign st_waddr = slot_add(oldest_slot_reg, {1'b0, held_count_reg});
    assign st_re    = cmd.fetch_oldest || cmd.rd_check || cmd.rd_addr;

    always_comb
    begin
        priority if (cmd.rd_check)
        begin
            st_raddr = slot_add(oldest_slot_reg, {1'b0, read_msg_reg});
        end
        else if (cmd.rd_addr)
        begin
            st_raddr = slot_add(oldest_slot_reg, {1'b0, read_msg_reg} + SW1'(1));
        end
        else
        begin
            st_raddr = oldest_slot_reg;
        end
    end

    mrl_ram #(
        .WIDTH (AW),
        .DEPTH (SLOTS)
    ) u_start_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (write_ptr_reg),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // byte store
    assign bs_we    = cmd.app_byte && !trunc_now;
    assign bs_raddr = ptr_add(st_rdata, read_ptr_reg);

    mrl_ram #(
        .WIDTH (DW),
        .DEPTH (STORE_BYTES)
    ) u_byte_ram (
        .clk   (clk),
        .we    (bs_we),
        .waddr (write_ptr_reg),
        .wdata (item_data_reg),
        .re    (cmd.rd_addr),
        .raddr (bs_raddr),
        .rdata (bs_rdata)
    );

    // pointer and counter updates
    always_comb
    begin
        oldest_slot_next = oldest_slot_reg;
        held_count_next  = held_count_reg;
        write_ptr_next   = write_ptr_reg;
        open_len_next    = open_len_reg;
        read_msg_next    = read_msg_reg;
        read_ptr_next    = read_ptr_reg;

        // eviction of the oldest message, cursor follows its message
        if (drop)
        begin
            oldest_slot_next = slot_add(oldest_slot_reg, SW1'(1));
            held_count_next  = held_count_reg - SW'(1);
            if (read_msg_reg != '0)
            begin
                read_msg_next = read_msg_reg - SW'(1);
            end
            else
            begin
                read_ptr_next = '0;
            end
        end

        // byte append and message close
        if (cmd.app_byte)
        begin
            if (!trunc_now)
            begin
                write_ptr_next = ptr_inc(write_ptr_reg);
                open_len_next  = open_len_reg + LW'(1);
            end
            if (item_last_reg)
            begin
                held_count_next = held_count_next + SW'(1);
                open_len_next   = '0;
            end
        end

        // read cursor
        if ((cmd.rd_check && past_end) || cmd.rewind)
        begin
            read_msg_next = '0;
            read_ptr_next = '0;
        end
        if (cmd.rd_finish)
        begin
            if (at_end)
            begin
                read_msg_next = read_msg_reg + SW'(1);
                read_ptr_next = '0;
            end
            else
            begin
                read_ptr_next = read_ptr_reg + AW'(1);
            end
        end

        if (cmd.clear_all)
        begin
            oldest_slot_next = '0;
            held_count_next  = '0;
            write_ptr_next   = '0;
            open_len_next    = '0;
            read_msg_next    = '0;
            read_ptr_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_slot_reg <= '0;
            held_count_reg  <= '0;
            write_ptr_reg   <= '0;
            open_len_reg    <= '0;
            read_msg_reg    <= '0;
            read_ptr_reg    <= '0;
        end
        else
        begin
            oldest_slot_reg <= oldest_slot_next;
            held_count_reg  <= held_count_next;
            write_ptr_reg   <= write_ptr_next;
            open_len_reg    <= open_len_next;
            read_msg_reg    <= read_msg_next;
            read_ptr_reg    <= read_ptr_next;
        end
    end

    // item capture and result collection
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_data_reg <= data;
            item_last_reg <= last;
            res_byte_reg  <= '0;
            res_mend_reg  <= 1'b0;
            res_lend_reg  <= 1'b0;
            res_trunc_reg <= 1'b0;
        end
        if (cmd.rd_check && past_end)
        begin
            res_lend_reg <= 1'b1;
        end
        if (cmd.rd_addr)
        begin
            start_reg <= st_rdata;
        end
        if (cmd.rd_finish)
        begin
            res_byte_reg <= bs_rdata;
            res_mend_reg <= at_end;
        end
        if (cmd.app_byte)
        begin
            res_trunc_reg <= trunc_now;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rd_byte_reg    <= res_byte_reg;
            msg_end_reg    <= res_mend_reg;
            log_end_reg    <= res_lend_reg;
            truncated_reg  <= res_trunc_reg;
            msg_count_reg  <= CNT_W'(held_count_reg);
            bytes_used_reg <= BYT_W'(bytes_now);
        end
    end

    assign rd_byte    = rd_byte_reg;
    assign msg_end    = msg_end_reg;
    assign log_end    = log_end_reg;
    assign msg_count  = msg_count_reg;
    assign bytes_used = bytes_used_reg;
    assign truncated  = truncated_reg;

    `MRL_ASSERT(a_held_bound, clk, rst_n, held_count_reg <= MSG_MAX, "held messages above limit")
    `MRL_ASSERT(a_cursor_bound, clk, rst_n, read_msg_reg <= held_count_reg, "read cursor past held messages")
    `MRL_ASSERT_NEXT(a_trunc_hold, clk, rst_n, cmd.app_byte && trunc_now, $stable(write_ptr_reg), "dropped byte moved write pointer")

endmodule

// ===== src/message_ring_log_unit.sv =====
// top level of the message ring log unit
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_ready  | op, data, last
//  out     | out_valid / out_ready| rd_byte, msg_end, log_end, msg_count, bytes_used,
//          |                      | truncated
//
// append and a read that returns a byte take more states than a read past the end,
// rewind and clear; the single read port of the message start memory sets this
// the next item is taken while a result waits in the output register
// reset clears pointers and counters only, the stores need no clearing pass
// a stalled output holds the finished item and the block waits before its next hand-over
module message_ring_log_unit #(
    parameter int STORE_BYTES = 256,
    parameter int MAX_MSGS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mrl_pkg::OP_W-1:0]      op,
    input  logic [mrl_pkg::DATA_W-1:0]    data,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mrl_pkg::DATA_W-1:0]    rd_byte,
    output logic                          msg_end,
    output logic                          log_end,
    output logic [mrl_pkg::COUNT_W-1:0]   msg_count,
    output logic [mrl_pkg::BYTES_W-1:0]   bytes_used,
    output logic                          truncated
);

    mrl_pkg::cmd_t    cmd;
    mrl_pkg::status_t status;

    // sequencing
    mrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // stores, pointers and result
    mrl_dpath #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_MSGS    (MAX_MSGS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .data       (data),
        .last       (last),
        .rd_byte    (rd_byte),
        .msg_end    (msg_end),
        .log_end    (log_end),
        .msg_count  (msg_count),
        .bytes_used (bytes_used),
        .truncated  (truncated)
    );

endmodule

// ===== verif/message_ring_log_unit_test.sv =====
// self-checking testbench of the message ring log unit
`timescale 1ns / 1ps

module message_ring_log_unit_test;

    localparam int STORE_BYTES  = 256;
    localparam int MAX_MSGS     = 16;
    localparam int SLOT_COUNT   = MAX_MSGS + 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 250;

    // one result item as the block reports it
    typedef struct packed {
        bit [mrl_pkg::DATA_W-1:0]  rd_byte;
        bit                        msg_end;
        bit                        log_end;
        bit [mrl_pkg::COUNT_W-1:0] msg_count;
        bit [mrl_pkg::BYTES_W-1:0] bytes_used;
        bit                        truncated;
    } log_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    mrl_pkg::op_t                 op;
    logic [mrl_pkg::DATA_W-1:0]   data;
    logic                         last;
    logic                         out_valid;
    logic                         out_ready;
    logic [mrl_pkg::DATA_W-1:0]   rd_byte;
    logic                         msg_end;
    logic                         log_end;
    logic [mrl_pkg::COUNT_W-1:0]  msg_count;
    logic [mrl_pkg::BYTES_W-1:0]  bytes_used;
    logic                         truncated;

    // mirror of the log contents and cursors
    bit [7:0] log_bytes [STORE_BYTES];
    bit [7:0] start_ring [SLOT_COUNT];
    bit [4:0] head_slot;
    bit [4:0] held;
    bit [7:0] wr_ptr;
    bit [8:0] open_len;
    bit [4:0] cur_msg;
    bit [8:0] cur_off;

    log_result_t pending_results [$];
    int          mismatches  = 0;
    int          sent_items  = 0;
    int          cycle_count = 0;
    bit          src_idle    = 1'b0;
    bit          sink_idle   = 1'b0;
    bit          hold_request = 1'b0;

    message_ring_log_unit #(
        .STORE_BYTES(STORE_BYTES),
        .MAX_MSGS   (MAX_MSGS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .data      (data),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rd_byte   (rd_byte),
        .msg_end   (msg_end),
        .log_end   (log_end),
        .msg_count (msg_count),
        .bytes_used(bytes_used),
        .truncated (truncated)
    );

    always #2 clk = ~clk;

    // ring slot of the k-th held message counted from the oldest
    function automatic bit [4:0] ring_slot(int k);
        return 5'((head_slot + k) % SLOT_COUNT);
    endfunction

    // store offset where the open or next message begins
    function automatic bit [7:0] open_base();
        bit [7:0] b;
        b = wr_ptr - open_len[7:0];
        return b;
    endfunction

    function automatic bit [8:0] msg_len(int k);
        bit [7:0] s;
        bit [7:0] e;
        bit [7:0] dlt;
        s = start_ring[ring_slot(k)];
        e = (k + 1 < held) ? start_ring[ring_slot(k + 1)] : open_base();
        dlt = e - s;
        return (dlt == 0) ? 9'(STORE_BYTES) : {1'b0, dlt};
    endfunction

    function automatic bit [8:0] bytes_in_use();
        bit [7:0] dlt;
        if (held == 0)
            return '0;
        dlt = open_base() - start_ring[head_slot];
        return (dlt == 0) ? 9'(STORE_BYTES) : {1'b0, dlt};
    endfunction

    // oldest message leaves; a cursor inside it falls to the new oldest
    function automatic void drop_oldest();
        if (held == 0)
            return;
        head_slot = 5'((head_slot + 1) % SLOT_COUNT);
        held--;
        if (cur_msg > 0)
            cur_msg--;
        else
            cur_off = '0;
    endfunction

    function automatic void empty_log();
        head_slot = '0;
        held      = '0;
        wr_ptr    = '0;
        open_len  = '0;
        cur_msg   = '0;
        cur_off   = '0;
    endfunction

    // advance the mirror by one item and return its result
    function automatic log_result_t apply_item(mrl_pkg::op_t o, bit [7:0] d, bit l);
        log_result_t r;
        bit [8:0]    len;
        bit [7:0]    idx;
        r = '0;
        unique case (o)
            mrl_pkg::OP_APPEND:
            begin
                if (open_len == 0)
                begin
                    if (held >= MAX_MSGS)
                        drop_oldest();
                    start_ring[ring_slot(held)] = wr_ptr;
                end
                if (open_len >= STORE_BYTES)
                    r.truncated = 1'b1;
                else
                begin
                    if (held > 0 && start_ring[head_slot] == wr_ptr)
                        drop_oldest();
                    log_bytes[wr_ptr] = d;
                    wr_ptr++;
                    open_len++;
                end
                if (l)
                begin
                    held++;
                    open_len = '0;
                end
            end
            mrl_pkg::OP_READ:
            begin
                if (cur_msg >= held)
                begin
                    r.log_end = 1'b1;
                    cur_msg   = '0;
                    cur_off   = '0;
                end
                else
                begin
                    len = msg_len(cur_msg);
                    idx = start_ring[ring_slot(cur_msg)] + cur_off[7:0];
                    r.rd_byte = log_bytes[idx];
                    cur_off++;
                    if (cur_off >= len)
                    begin
                        r.msg_end = 1'b1;
                        cur_msg++;
                        cur_off = '0;
                    end
                end
            end
            mrl_pkg::OP_REWIND:
            begin
                cur_msg = '0;
                cur_off = '0;
            end
            mrl_pkg::OP_CLEAR:
                empty_log();
        endcase
        r.msg_count  = held;
        r.bytes_used = bytes_in_use();
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // offer one item, wait for it to be taken, record what it should give
    task automatic send_item(mrl_pkg::op_t o, bit [7:0] d, bit l);
        int gap;
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        data     <= d;
        last     <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(apply_item(o, d, l));
        sent_items++;
    endtask

    // one whole message, now and then a read slipped in while it is open
    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(mrl_pkg::OP_READ, 8'($urandom), 1'($urandom));
            send_item(mrl_pkg::OP_APPEND, 8'($urandom), i == len - 1);
        end
    endtask

    task automatic send_reads(int n);
        for (int i = 0; i < n; i++)
            send_item(mrl_pkg::OP_READ, 8'($urandom), 1'($urandom));
    endtask

    // extremes of the byte, open message, read past the end, rewind, clear
    task automatic test_directed();
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_CLEAR,  8'h00, 1'b0);
        send_item(mrl_pkg::OP_APPEND, 8'h00, 1'b1);
        send_item(mrl_pkg::OP_APPEND, 8'hFF, 1'b0);
        send_item(mrl_pkg::OP_READ,   8'hFF, 1'b1);
        send_item(mrl_pkg::OP_APPEND, 8'hAA, 1'b1);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_APPEND, 8'h55, 1'b0);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_REWIND, 8'hFF, 1'b1);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_APPEND, 8'h7F, 1'b1);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_CLEAR,  8'hFF, 1'b1);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
        send_item(mrl_pkg::OP_APPEND, 8'h81, 1'b1);
        send_item(mrl_pkg::OP_READ,   8'h00, 1'b0);
    endtask

    // message limit reached, with the cursor inside and past the oldest
    task automatic test_count_limit();
        send_item(mrl_pkg::OP_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < MAX_MSGS; i++)
            send_message(2);
        send_reads(1);
        send_message(2);
        send_reads(3);
        send_message(2);
        send_reads(40);
    endtask

    // message longer than the store sweeps out the others and is cut short
    task automatic test_overlong();
        send_item(mrl_pkg::OP_CLEAR, 8'h00, 1'b0);
        send_message(3);
        send_message(3);
        send_reads(2);
        for (int i = 0; i < STORE_BYTES + 6; i++)
            send_item(mrl_pkg::OP_APPEND, 8'($urandom), i == STORE_BYTES + 5);
        send_reads(STORE_BYTES + 2);
        send_message(3);
        send_reads(5);
    endtask

    // receiver stalls for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            send_message($urandom_range(2, 6));
            send_reads($urandom_range(2, 6));
        end
    endtask

    // mostly whole messages and read runs, with some noise items
    task automatic test_random_traffic(int n_items);
        int stop_at;
        int pick;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_message(($urandom_range(0, 7) == 0) ? $urandom_range(20, 90)
                                                          : $urandom_range(1, 12));
            else if (pick < 80)
                send_reads($urandom_range(1, 24));
            else if (pick < 88)
                send_item(mrl_pkg::OP_REWIND, 8'($urandom), 1'($urandom));
            else if (pick < 91)
                send_item(mrl_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
            else
                send_item(mrl_pkg::op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end
    endtask

    // receiver ready pattern: long hold when asked, else random bursts
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // compare each result taken with the oldest expectation
    always @(posedge clk)
    begin
        log_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result item with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                check_field("rd_byte",    rd_byte,    want.rd_byte);
                check_field("msg_end",    msg_end,    want.msg_end);
                check_field("log_end",    log_end,    want.log_end);
                check_field("msg_count",  msg_count,  want.msg_count);
                check_field("bytes_used", bytes_used, want.bytes_used);
                check_field("truncated",  truncated,  want.truncated);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        op       <= mrl_pkg::OP_APPEND;
        data     <= '0;
        last     <= 1'b0;
        empty_log();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        test_directed();
        test_count_limit();
        test_overlong();
        test_backpressure();
        test_random_traffic(260);

        // closing stretch at full rate
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        test_random_traffic(150);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/mrl_pkg.sv
src/mrl_ram.sv
src/mrl_ctrl.sv
src/mrl_dpath.sv
src/message_ring_log_unit.sv
verif/message_ring_log_unit_test.sv
